// ===== sv/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types, constants and register codes of the find-and-replace core
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  localparam int ByteW   = 8;
  localparam int MaxPat  = 8;   // pattern bytes
  localparam int MaxWord = 8;   // replacement bytes
  localparam int MaxOut  = 8;   // results per source byte
  localparam int WinD    = 7;   // pending window depth
  localparam int CntW    = 3;   // pending count width
  localparam int LenW    = 4;   // length register width
  localparam int RegW    = 64;  // wide register width
  localparam int IdxW    = 3;   // config index width

  // replace modes
  localparam logic MODE_TOKEN  = 1'b0;
  localparam logic MODE_STRING = 1'b1;

  // configuration register indexes
  typedef enum logic [IdxW-1:0] {
    REG_MODE       = 3'd0,
    REG_PAT_BYTES  = 3'd1,
    REG_PAT_LEN    = 3'd2,
    REG_WORD_BYTES = 3'd3,
    REG_WORD_LEN   = 3'd4
  } sfr_reg_t;

  typedef logic [ByteW-1:0] byte_t;

  typedef struct packed {
    logic              mode;
    logic [RegW-1:0]   pat;
    logic [LenW-1:0]   plen;
    logic [RegW-1:0]   word;
    logic [LenW-1:0]   wlen;
  } sfr_cfg_t;

  // results caused by one source byte
  typedef struct packed {
    logic [MaxOut-1:0][ByteW-1:0] bytes;
    logic [LenW-1:0]              count;
    logic                         last;
    logic                         marker;
  } sfr_batch_t;

endpackage

`default_nettype wire

// ===== sv/sfr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sfr_cfg_regs
// configuration registers, write channel and pending-window clear pulse
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_cfg_regs
  import sfr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IdxW-1:0]  cfg_index,
  input  wire logic [RegW-1:0]  cfg_data,
  output sfr_cfg_t              cfg,
  output logic                  clear
);

  always_comb begin
    cfg_ready = 1'b1;
    unique case (cfg_index)
      REG_MODE, REG_PAT_BYTES, REG_PAT_LEN, REG_WORD_BYTES, REG_WORD_LEN: clear = cfg_valid;
      default: clear = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= MODE_TOKEN;
      cfg.pat  <= '0;
      cfg.plen <= LenW'(1);
      cfg.word <= '0;
      cfg.wlen <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:       cfg.mode <= cfg_data[0];
        REG_PAT_BYTES:  cfg.pat  <= cfg_data;
        REG_PAT_LEN:    cfg.plen <= cfg_data[LenW-1:0];
        REG_WORD_BYTES: cfg.word <= cfg_data;
        REG_WORD_LEN:   cfg.wlen <= cfg_data[LenW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/sfr_rewrite.sv =====
// ----------------------------------------------------------------------------
// sfr_rewrite
// input register, pending window and single-pass match/rewrite logic
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_rewrite
  import sfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sfr_cfg_t          cfg,
  input  wire logic              clear,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [ByteW-1:0]  in_byte,
  input  wire logic              in_last,
  input  wire logic              free,
  output logic                   load,
  output sfr_batch_t             batch
);

  logic                          stage_valid;
  byte_t                         stage_byte;
  logic                          stage_last;
  byte_t                         win [WinD];
  byte_t                         win_next [WinD];
  logic [CntW-1:0]               pend_cnt;
  logic [CntW-1:0]               pend_cnt_next;

  logic [LenW-1:0]               plen_eff;
  logic [LenW-1:0]               wlen_eff;
  logic                          token_path;
  logic [CntW-1:0]               start_cnt;
  logic [LenW-1:0]               fill;
  logic [MaxOut-1:0][ByteW-1:0]  a;
  logic [MaxOut-1:0]             m;
  logic                          hit;
  logic [LenW-1:0]               shift;
  logic                          word_out;

  assign load     = stage_valid && free;
  assign in_ready = !stage_valid || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_byte <= in_byte;
      stage_last <= in_last;
    end
  end

  always_comb begin
    plen_eff   = (cfg.plen > LenW'(MaxPat)) ? LenW'(MaxPat) : cfg.plen;
    wlen_eff   = (cfg.wlen > LenW'(MaxWord)) ? LenW'(MaxWord) : cfg.wlen;
    token_path = (cfg.mode == MODE_TOKEN) || (plen_eff == '0);
    start_cnt  = (token_path || ({1'b0, pend_cnt} >= plen_eff)) ? '0 : pend_cnt;
    fill       = {1'b0, start_cnt} + LenW'(1);
  end

  // window with the new byte appended
  always_comb begin
    a[MaxOut-1] = stage_byte;
    for (int i = 0; i < WinD; i++) begin
      a[i] = (CntW'(i) < start_cnt) ? win[i] : stage_byte;
    end
  end

  // token hit against any active pattern byte
  always_comb begin
    hit = 1'b0;
    for (int j = 0; j < MaxPat; j++) begin
      if ((LenW'(j) < plen_eff) && (cfg.pat[j*ByteW +: ByteW] == stage_byte)) begin
        hit = 1'b1;
      end
    end
  end

  // for each shift: does the held tail match the pattern prefix
  always_comb begin
    for (int s = 0; s < MaxOut; s++) begin
      m[s] = 1'b1;
      for (int j = 0; j < MaxPat; j++) begin
        if ((s + j < MaxOut) && (LenW'(s + j) < fill) &&
            (a[s+j] != cfg.pat[j*ByteW +: ByteW])) begin
          m[s] = 1'b0;
        end
      end
    end
  end

  // smallest shift that leaves a live prefix
  always_comb begin
    shift = fill;
    for (int s = MaxOut - 1; s >= 0; s--) begin
      if ((LenW'(s) < fill) && m[s]) begin
        shift = LenW'(s);
      end
    end
  end

  always_comb begin
    logic [LenW:0] idx;
    idx = '0;
    word_out = token_path ? ((cfg.mode == MODE_TOKEN) && hit)
                          : (m[0] && (fill == plen_eff));
    for (int i = 0; i < MaxOut; i++) begin
      batch.bytes[i] = word_out ? cfg.word[i*ByteW +: ByteW] : a[i];
    end
    if (word_out) begin
      batch.count = wlen_eff;
    end else if (token_path) begin
      batch.count = LenW'(1);
    end else if (stage_last) begin
      batch.count = fill;
    end else begin
      batch.count = shift;
    end
    batch.last   = stage_last;
    batch.marker = 1'b0;
    if (stage_last && (batch.count == '0)) begin
      batch.marker   = 1'b1;
      batch.count    = LenW'(1);
      batch.bytes[0] = '0;
    end
    for (int j = 0; j < WinD; j++) begin
      idx         = {1'b0, shift} + (LenW+1)'(j);
      win_next[j] = a[idx[CntW-1:0]];
    end
    if (token_path || word_out || stage_last) begin
      pend_cnt_next = '0;
    end else begin
      pend_cnt_next = CntW'(fill - shift);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt <= '0;
    end else if (clear) begin
      pend_cnt <= '0;
    end else if (load) begin
      pend_cnt <= pend_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      win <= win_next;
    end
  end

  a_pend_below_plen: assert property (@(posedge clk) disable iff (rst)
    (pend_cnt != '0) |-> ({1'b0, pend_cnt} < plen_eff))
    else $error("pending window holds a full pattern");

  a_last_flushes: assert property (@(posedge clk) disable iff (rst)
    (load && stage_last) |=> (pend_cnt == '0))
    else $error("pending window not flushed on last byte");

endmodule

`default_nettype wire

// ===== sv/sfr_out_buf.sv =====
// ----------------------------------------------------------------------------
// sfr_out_buf
// result register: holds one batch and, while m_tready is high, drains it one result per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_out_buf
  import sfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire sfr_batch_t        batch,
  output logic                   free,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [ByteW-1:0]       m_tdata,
  output logic [0:0]             m_tuser,
  output logic                   m_tlast
);

  logic [MaxOut-1:0][ByteW-1:0]  bytes;
  logic [LenW-1:0]               rem;
  logic [CntW-1:0]               pos;
  logic                          last;
  logic                          marker;

  assign m_tvalid = (rem != '0);
  assign m_tdata  = bytes[pos];
  assign m_tuser  = !marker;
  assign m_tlast  = last && (rem == LenW'(1));
  assign free     = (rem == '0) || ((rem == LenW'(1)) && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      pos <= '0;
    end else if (load) begin
      rem <= batch.count;
      pos <= '0;
    end else if (m_tvalid && m_tready) begin
      rem <= rem - LenW'(1);
      pos <= pos + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes  <= batch.bytes;
      last   <= batch.last;
      marker <= batch.marker;
    end
  end

  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && marker) |-> m_tlast)
    else $error("end marker not flagged last");

  a_drain_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !load) |=> (rem == $past(rem) - LenW'(1)))
    else $error("result count did not step on transaction");

endmodule

`default_nettype wire

// ===== sv/stream_find_replace_core.sv =====
// ----------------------------------------------------------------------------
// stream_find_replace_core
// streaming find-and-replace over a byte stream
// ----------------------------------------------------------------------------
// Source bytes enter on the s_ stream with tlast on the final byte of a
// string; the rewritten string leaves on the m_ stream. In token mode every
// byte equal to one of the active pattern bytes becomes the replacement word;
// in string mode non-overlapping occurrences of the pattern sequence, scanned
// left to right, become the word, and up to seven bytes that may still start
// a match are held back and flushed on the last byte. A string that ends with
// no output byte yields one result with m_tuser low and tlast high. Each
// source byte is latched in an input register and rewritten in one pass into
// a result register that holds all of its results (0 to 8); the result
// register drains one result per cycle while m_tready is high and takes the
// next batch in the cycle its final result leaves. While a batch drains, the
// next source byte waits in the input register until the result register is
// free, set by the single output port of the result register. The first
// result passes through the input register and then the result register.
// Configuration is to be written only while idle, by the user; the block
// itself does not enforce it. Any write to a defined register discards the pending window.
`default_nettype none

module stream_find_replace_core
  import sfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // source stream
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [ByteW-1:0]  s_tdata,   // [7:0] in_byte
  input  wire logic              s_tlast,   // in_last
  // rewritten stream
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [ByteW-1:0]       m_tdata,   // [7:0] out_byte
  output logic [0:0]             m_tuser,   // [0] out_valid
  output logic                   m_tlast,   // out_last
  // configuration write channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [IdxW-1:0]   cfg_index,
  input  wire logic [RegW-1:0]   cfg_data
);

  sfr_cfg_t    cfg;
  logic        clear;     // pending window discard on config write
  logic        free;      // result register can take a batch this cycle
  logic        load;      // batch moves into the result register
  sfr_batch_t  batch;

  // register file
  sfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .clear     (clear)
  );

  // input register, pending window and match logic
  sfr_rewrite u_rewrite (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .clear    (clear),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .free     (free),
    .load     (load),
    .batch    (batch)
  );

  // result register, one transaction per cycle while m_tready is high
  sfr_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .batch    (batch),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
